// ----- design/vdsa_pkg.sv -----
// ---------------------------------------------------------------------------
// vdsa_pkg - shared types and constants of the voxel dose scoring accumulator
// Field widths, status codes, register indexes and the digit-serial unit's
// command and result bundles.
// ---------------------------------------------------------------------------
`default_nettype none
package vdsa_pkg;

   localparam int unsigned VOXEL_DEPTH = 65536;
   localparam int unsigned INDEX_BITS  = 16;
   localparam int unsigned ENERGY_BITS = 24;
   localparam int unsigned COORD_BITS  = 8;
   localparam int unsigned SIZE_BITS   = 9;
   localparam int unsigned SCALE_BITS  = 24;
   localparam int unsigned SUM_BITS    = 48;
   localparam int unsigned SQ_BITS     = 64;
   localparam int unsigned CNT_BITS    = 32;
   localparam int unsigned WIDE_BITS   = 128;

   // status codes
   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_RANGE  = 2'd1;
   localparam logic [1:0] STATUS_ABSENT = 2'd2;

   // request kinds
   localparam logic REQ_DEPOSIT = 1'b0;
   localparam logic REQ_QUERY   = 1'b1;

   // register indexes
   localparam logic [1:0] REG_SIZE_X = 2'd0;
   localparam logic [1:0] REG_SIZE_Y = 2'd1;
   localparam logic [1:0] REG_SIZE_Z = 2'd2;
   localparam logic [1:0] REG_SCALE  = 2'd3;

   localparam logic [SUM_BITS-1:0] SUM_MAX = {SUM_BITS{1'b1}};
   localparam logic [63:0]         ONE_Q12 = 64'd4096;

   // request to the statistics unit
   typedef struct packed {
      logic                  start;
      logic [CNT_BITS-1:0]   count;
      logic [SUM_BITS-1:0]   sum;
      logic [SQ_BITS-1:0]    sq_sum;
      logic [SCALE_BITS-1:0] scale;
   } stat_cmd_type;

   // answer of the statistics unit
   typedef struct packed {
      logic                busy;
      logic                done;
      logic [SUM_BITS-1:0] dose;
      logic [SUM_BITS-1:0] error;
   } stat_rsp_type;

endpackage
`default_nettype wire

// ----- design/vdsa_stat.sv -----
// ---------------------------------------------------------------------------
// vdsa_stat - digit-serial dose and error evaluation
// Runs, one bit per cycle: n*S2 and S*S by shift-add, the difference,
// restoring division by n-1, bit-pair square root, then two shift-add
// scalings by the factor with saturation; under two events, scalings only.
// ---------------------------------------------------------------------------
`default_nettype none
module vdsa_stat (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire vdsa_pkg::stat_cmd_type cmd,
   output      vdsa_pkg::stat_rsp_type rsp
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_MULN, ST_MULS, ST_DIFF, ST_DIV, ST_SQRT,
      ST_SCL_S, ST_SCL_E, ST_DONE
   } state_type;

   state_type state_ff;
   logic [7:0]   step_ff;
   logic [31:0]  n_ff;
   logic [47:0]  s_ff;
   logic [63:0]  s2_ff;
   logic [23:0]  f_ff;
   logic [127:0] acc_ff;     // product / difference / quotient
   logic [127:0] aux_ff;     // shifting operand; radicand pairs for the root
   logic [127:0] rem_ff;     // S*S product, remainder of divide / root
   logic [63:0]  root_ff;
   logic [87:0]  sacc_ff;    // scaling product
   logic [47:0]  dose_ff;
   logic [47:0]  err_ff;

   logic [128:0] rtrial;
   logic [129:0] qtrial;
   logic [127:0] rshift;
   logic [129:0] qshift;
   logic [63:0]  evalue;

   // trial subtraction for divide and root
   always_comb begin
      rshift = {rem_ff[126:0], acc_ff[127]};
      rtrial = {1'b0, rshift} - {97'd0, n_ff - 32'd1};
      qshift = {rem_ff, aux_ff[127:126]};
      qtrial = qshift - {64'd0, root_ff, 2'b01};
      evalue = (n_ff < 32'd2) ? vdsa_pkg::ONE_Q12 : root_ff;
   end

   function automatic logic [47:0] sat48(input logic [87:0] p);
      sat48 = (p[87:64] != 24'd0) ? vdsa_pkg::SUM_MAX : p[63:16];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (cmd.start) begin
                  n_ff     <= cmd.count;
                  s_ff     <= cmd.sum;
                  s2_ff    <= cmd.sq_sum;
                  f_ff     <= cmd.scale;
                  acc_ff   <= '0;
                  aux_ff   <= {64'd0, cmd.sq_sum};
                  step_ff  <= '0;
                  state_ff <= (cmd.count < 32'd2) ? ST_SCL_S : ST_MULN;
                  sacc_ff  <= '0;
               end
            end
            // n * S2, one bit of n per cycle
            ST_MULN: begin
               if (n_ff[step_ff[4:0]]) acc_ff <= acc_ff + aux_ff;
               if (step_ff == 8'd31) begin
                  step_ff  <= '0;
                  rem_ff   <= '0;
                  aux_ff   <= {80'd0, s_ff};
                  state_ff <= ST_MULS;
               end else begin
                  aux_ff  <= aux_ff << 1;
                  step_ff <= step_ff + 8'd1;
               end
            end
            // S * S into rem
            ST_MULS: begin
               if (s_ff[step_ff[5:0]]) rem_ff <= rem_ff + aux_ff;
               if (step_ff == 8'd47) begin
                  step_ff  <= '0;
                  state_ff <= ST_DIFF;
               end else begin
                  aux_ff  <= aux_ff << 1;
                  step_ff <= step_ff + 8'd1;
               end
            end
            ST_DIFF: begin
               acc_ff   <= (acc_ff <= rem_ff) ? '0 : acc_ff - rem_ff;
               rem_ff   <= '0;
               state_ff <= ST_DIV;
            end
            // restoring divide by n-1, quotient shifts into acc
            ST_DIV: begin
               if (!rtrial[128]) begin
                  rem_ff <= rtrial[127:0];
                  acc_ff <= {acc_ff[126:0], 1'b1};
               end else begin
                  rem_ff <= rshift;
                  acc_ff <= {acc_ff[126:0], 1'b0};
               end
               if (step_ff == 8'd127) begin
                  step_ff  <= '0;
                  state_ff <= ST_SQRT;
                  root_ff  <= '0;
               end else begin
                  step_ff <= step_ff + 8'd1;
               end
            end
            // bit-pair square root: acc pairs feed via aux
            ST_SQRT: begin
               if (step_ff == 8'd0) begin
                  aux_ff <= acc_ff;
                  rem_ff <= '0;
                  step_ff <= 8'd1;
               end else begin
                  aux_ff <= aux_ff << 2;
                  if (!qtrial[129]) begin
                     rem_ff  <= qtrial[127:0];
                     root_ff <= {root_ff[62:0], 1'b1};
                  end else begin
                     rem_ff  <= qshift[127:0];
                     root_ff <= {root_ff[62:0], 1'b0};
                  end
                  if (step_ff == 8'd64) begin
                     step_ff  <= '0;
                     sacc_ff  <= '0;
                     state_ff <= ST_SCL_S;
                  end else begin
                     step_ff <= step_ff + 8'd1;
                  end
               end
            end
            // S * factor, one factor bit per cycle
            ST_SCL_S: begin
               if (step_ff == 8'd24) begin
                  dose_ff  <= sat48(sacc_ff);
                  sacc_ff  <= '0;
                  step_ff  <= '0;
                  state_ff <= ST_SCL_E;
               end else begin
                  if (f_ff[step_ff[4:0]])
                     sacc_ff <= sacc_ff + ({40'd0, s_ff} << step_ff[4:0]);
                  step_ff <= step_ff + 8'd1;
               end
            end
            ST_SCL_E: begin
               if (step_ff == 8'd24) begin
                  err_ff   <= sat48(sacc_ff);
                  step_ff  <= '0;
                  state_ff <= ST_DONE;
               end else begin
                  if (f_ff[step_ff[4:0]])
                     sacc_ff <= sacc_ff + ({24'd0, evalue} << step_ff[4:0]);
                  step_ff <= step_ff + 8'd1;
               end
            end
            ST_DONE: state_ff <= ST_IDLE;
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp.busy  = (state_ff != ST_IDLE);
   assign rsp.done  = (state_ff == ST_DONE);
   assign rsp.dose  = dose_ff;
   assign rsp.error = err_ff;

   // done lasts one cycle
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp.done |=> !rsp.done) else $error("done held");
   // a start while idle is taken; none is taken while busy
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.start && state_ff == ST_IDLE) |=> rsp.busy) else $error("start lost");
   // division ends in root extraction
   a_div_root: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && step_ff == 8'd127) |=> state_ff == ST_SQRT)
      else $error("div sequencing");

endmodule
`default_nettype wire

// ----- design/voxel_dose_scoring_accumulator.sv -----
// ---------------------------------------------------------------------------
// voxel_dose_scoring_accumulator - per-voxel energy sum, square sum, count
// Deposits read-modify-write the voxel stores; queries run the serial
// statistics unit for the scaled dose and error.
// ---------------------------------------------------------------------------
//  channel | direction | fields
//  req_    | in        | tuser: req_type; tdata: x, y, z, energy
//  rsp_    | out       | tdata: status, dose, abs_error, event_count
//  csr_    | in        | size_x, size_y, size_z, scale_factor
//
// Index: x + size_x*(y + size_y*z), formed serially by shift-add multiplies.
// Deposit: index, memory read, then update. Query: two or more events run
// the bit-serial multiply, 128-step divide and 64-step root before scaling,
// fewer run scaling only, an absent voxel none. Coordinates out of range
// are caught in the check, an index too large after the multiplies. After
// reset a clearing pass sweeps the 65536-entry valid store; no request is
// taken meanwhile. A waiting result holds in the output register; the next
// result waits behind it and the input stalls until it moves on.
`default_nettype none
module voxel_dose_scoring_accumulator (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output      logic         req_tready,
   input  wire logic [47:0]  req_tdata,   // x[7:0], y[15:8], z[23:16], energy[47:24]
   input  wire logic         req_tuser,   // req_type
   output      logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   output      logic [135:0] rsp_tdata,   // status[1:0], dose[49:2],
                                          // abs_error[97:50], event_count[129:98]
   input  wire logic         csr_psel,
   input  wire logic         csr_penable,
   input  wire logic         csr_pwrite,
   input  wire logic [3:0]   csr_paddr,
   input  wire logic [31:0]  csr_pwdata,
   output      logic [31:0]  csr_prdata,
   output      logic         csr_pready
);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_CHECK, S_MULA, S_MULB, S_RANGE, S_READ, S_WAIT,
      S_UPDATE, S_STAT, S_RESULT
   } state_type;

   // registers
   logic [8:0]  size_x_ff, size_y_ff, size_z_ff;
   logic [23:0] scale_ff;

   assign csr_pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff <= 9'd1;
         size_y_ff <= 9'd1;
         size_z_ff <= 9'd1;
         scale_ff  <= 24'd65536;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (csr_paddr[3:2])
            vdsa_pkg::REG_SIZE_X: size_x_ff <= csr_pwdata[8:0];
            vdsa_pkg::REG_SIZE_Y: size_y_ff <= csr_pwdata[8:0];
            vdsa_pkg::REG_SIZE_Z: size_z_ff <= csr_pwdata[8:0];
            vdsa_pkg::REG_SCALE:  scale_ff  <= csr_pwdata[23:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         vdsa_pkg::REG_SIZE_X: csr_prdata = {23'd0, size_x_ff};
         vdsa_pkg::REG_SIZE_Y: csr_prdata = {23'd0, size_y_ff};
         vdsa_pkg::REG_SIZE_Z: csr_prdata = {23'd0, size_z_ff};
         vdsa_pkg::REG_SCALE:  csr_prdata = {8'd0, scale_ff};
         default:              csr_prdata = '0;
      endcase
   end

   // voxel stores
   logic        valid_mem [vdsa_pkg::VOXEL_DEPTH];
   logic [47:0] sum_mem   [vdsa_pkg::VOXEL_DEPTH];
   logic [63:0] sq_mem    [vdsa_pkg::VOXEL_DEPTH];
   logic [31:0] cnt_mem   [vdsa_pkg::VOXEL_DEPTH];

   state_type   state_ff;
   logic [15:0] clr_ff;
   logic        kind_ff;
   logic [7:0]  x_ff, y_ff, z_ff;
   logic [23:0] e_ff;
   logic [3:0]  bit_ff;
   logic [26:0] idx_ff;     // running index, wide enough for overflow
   logic [17:0] yz_ff;      // y + size_y*z
   logic        rd_valid_ff;
   logic [47:0] rd_sum_ff;
   logic [63:0] rd_sq_ff;
   logic [31:0] rd_cnt_ff;
   logic [135:0] res_ff;    // finished result waiting for the output register
   logic [135:0] out_ff;
   logic        out_valid_ff;
   logic        out_load;
   logic [15:0] vidx;

   vdsa_pkg::stat_cmd_type stat_cmd;
   vdsa_pkg::stat_rsp_type stat_rsp;

   assign vidx = idx_ff[15:0];

   // deposit update values
   logic [48:0] sum_add;
   logic [64:0] sq_add;
   logic [47:0] sq_e;
   logic [47:0] new_sum;
   logic [63:0] new_sq;
   logic [31:0] new_cnt;
   always_comb begin
      sq_e    = {24'd0, e_ff} * {24'd0, e_ff};
      sum_add = {1'b0, rd_sum_ff} + {25'd0, e_ff};
      sq_add  = {1'b0, rd_sq_ff} + {17'd0, sq_e};
      if (!rd_valid_ff) begin
         new_sum = {24'd0, e_ff};
         new_sq  = {16'd0, sq_e};
         new_cnt = 32'd1;
      end else begin
         new_sum = sum_add[48] ? vdsa_pkg::SUM_MAX : sum_add[47:0];
         new_sq  = sq_add[64] ? {64{1'b1}} : sq_add[63:0];
         new_cnt = (rd_cnt_ff == {32{1'b1}}) ? rd_cnt_ff : rd_cnt_ff + 32'd1;
      end
   end

   assign stat_cmd.start  = (state_ff == S_WAIT) && kind_ff && rd_valid_ff;
   assign stat_cmd.count  = rd_cnt_ff;
   assign stat_cmd.sum    = rd_sum_ff;
   assign stat_cmd.sq_sum = rd_sq_ff;
   assign stat_cmd.scale  = scale_ff;

   vdsa_stat u_stat (
      .clock (clock),
      .reset (reset),
      .cmd   (stat_cmd),
      .rsp   (stat_rsp)
   );

   // memory ports
   always_ff @(posedge clock) begin
      if (state_ff == S_CLEAR) valid_mem[clr_ff] <= 1'b0;
      else if (state_ff == S_UPDATE && !kind_ff) begin
         valid_mem[vidx] <= 1'b1;
         sum_mem[vidx]   <= new_sum;
         sq_mem[vidx]    <= new_sq;
         cnt_mem[vidx]   <= new_cnt;
      end
      if (state_ff == S_READ) begin
         rd_valid_ff <= valid_mem[vidx];
         rd_sum_ff   <= sum_mem[vidx];
         rd_sq_ff    <= sq_mem[vidx];
         rd_cnt_ff   <= cnt_mem[vidx];
      end
   end

   // result moves to the output register once that is free
   assign out_load = (state_ff == S_RESULT) && (!out_valid_ff || rsp_tready);

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_load || (out_valid_ff && !rsp_tready);
         unique case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 16'd1;
               if (clr_ff == 16'hFFFF) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (req_tvalid) begin
                  kind_ff  <= req_tuser;
                  x_ff     <= req_tdata[7:0];
                  y_ff     <= req_tdata[15:8];
                  z_ff     <= req_tdata[23:16];
                  e_ff     <= req_tdata[47:24];
                  state_ff <= S_CHECK;
               end
            end
            S_CHECK: begin
               if ({1'b0, x_ff} >= size_x_ff || {1'b0, y_ff} >= size_y_ff ||
                   {1'b0, z_ff} >= size_z_ff) begin
                  res_ff   <= {34'd0, 96'd0, 4'd0, vdsa_pkg::STATUS_RANGE};
                  state_ff <= S_RESULT;
               end else begin
                  yz_ff    <= {10'd0, y_ff};
                  bit_ff   <= '0;
                  state_ff <= S_MULA;
               end
            end
            // yz = y + size_y*z, one bit of size_y per cycle
            S_MULA: begin
               if (size_y_ff[bit_ff]) yz_ff <= yz_ff + ({10'd0, z_ff} << bit_ff);
               if (bit_ff == 4'd8) begin
                  bit_ff   <= '0;
                  idx_ff   <= {19'd0, x_ff};
                  state_ff <= S_MULB;
               end else begin
                  bit_ff <= bit_ff + 4'd1;
               end
            end
            // idx = x + size_x*yz
            S_MULB: begin
               if (size_x_ff[bit_ff]) idx_ff <= idx_ff + ({9'd0, yz_ff} << bit_ff);
               if (bit_ff == 4'd8) state_ff <= S_RANGE;
               else bit_ff <= bit_ff + 4'd1;
            end
            S_RANGE: begin
               if (idx_ff[26:16] != 11'd0) begin
                  res_ff   <= {134'd0, vdsa_pkg::STATUS_RANGE};
                  state_ff <= S_RESULT;
               end else state_ff <= S_READ;
            end
            S_READ: state_ff <= S_WAIT;
            S_WAIT: begin
               if (!kind_ff) state_ff <= S_UPDATE;
               else if (!rd_valid_ff) begin
                  res_ff   <= {134'd0, vdsa_pkg::STATUS_ABSENT};
                  state_ff <= S_RESULT;
               end else state_ff <= S_STAT;
            end
            S_UPDATE: begin
               res_ff   <= {6'd0, new_cnt, 96'd0, vdsa_pkg::STATUS_OK};
               state_ff <= S_RESULT;
            end
            S_STAT: begin
               if (stat_rsp.done) begin
                  res_ff   <= {6'd0, rd_cnt_ff, stat_rsp.error, stat_rsp.dose,
                               vdsa_pkg::STATUS_OK};
                  state_ff <= S_RESULT;
               end
            end
            S_RESULT: begin
               if (out_load) begin
                  out_ff   <= res_ff;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff;

   // no request during the clearing pass
   a_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |-> !req_tready) else $error("request in clear");
   // statistics unit only runs for a query
   a_stat_query: assert property (@(posedge clock) disable iff (reset)
      stat_cmd.start |-> kind_ff == vdsa_pkg::REQ_QUERY) else $error("stat for deposit");
   // an accepted request goes on to the coordinate check
   a_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> state_ff == S_CHECK) else $error("accept lost");

endmodule
`default_nettype wire
